// ===== hdl/citf_pkg.sv =====
// Package with the shared types and constants of the conditional init table filter.
package citf_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_WIDTH = 30;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam int BRANCH_BIT = 31;
   localparam int CHECK_BIT = 30;

   typedef enum logic [1:0] {
      BR_IF    = 2'd0,
      BR_ELIF  = 2'd1,
      BR_ELSE  = 2'd2,
      BR_ENDIF = 2'd3
   } branch_type;

   typedef enum logic [2:0] {
      REG_DEV_RFE  = 3'd0,
      REG_DEV_INTF = 3'd1,
      REG_DEV_PKG  = 3'd2,
      REG_DEV_PLAT = 3'd3,
      REG_DEV_CUT  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [7:0] rfe;
      logic [3:0] intf;
      logic [3:0] pkg;
      logic [3:0] plat;
      logic [3:0] cut;
   } cond_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] addr;
      logic [DATA_WIDTH-1:0] data;
   } write_type;

   localparam cond_type COND_RESET = '{rfe: 8'd0, intf: 4'd0, pkg: 4'd0, plat: 4'd0,
                                       cut: 4'd0};

endpackage

// ===== hdl/citf_csr.sv =====
// Configuration registers holding the device fields, with an APB-style access port.
module citf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [citf_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [citf_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [citf_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output citf_pkg::cond_type                  dev_cfg
);
   import citf_pkg::*;

   cond_type      dev_ff;
   cond_type      dev_in;
   logic          write_en;
   reg_index_type reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign dev_cfg    = dev_ff;

   always_comb begin
      dev_in = dev_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_DEV_RFE:  dev_in.rfe  = csr_pwdata[7:0];
            REG_DEV_INTF: dev_in.intf = csr_pwdata[3:0];
            REG_DEV_PKG:  dev_in.pkg  = csr_pwdata[3:0];
            REG_DEV_PLAT: dev_in.plat = csr_pwdata[3:0];
            REG_DEV_CUT:  dev_in.cut  = csr_pwdata[3:0];
            default:      dev_in      = dev_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DEV_RFE:  csr_prdata = {{(CSR_DATA_WIDTH-8){1'b0}}, dev_ff.rfe};
         REG_DEV_INTF: csr_prdata = {{(CSR_DATA_WIDTH-4){1'b0}}, dev_ff.intf};
         REG_DEV_PKG:  csr_prdata = {{(CSR_DATA_WIDTH-4){1'b0}}, dev_ff.pkg};
         REG_DEV_PLAT: csr_prdata = {{(CSR_DATA_WIDTH-4){1'b0}}, dev_ff.plat};
         REG_DEV_CUT:  csr_prdata = {{(CSR_DATA_WIDTH-4){1'b0}}, dev_ff.cut};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= COND_RESET;
      end else begin
         dev_ff <= dev_in;
      end
   end

endmodule

// ===== hdl/citf_core.sv =====
// Input register, table state and entry decode that selects the writes to pass.
module citf_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [citf_pkg::WORD_WIDTH-1:0] req_entry_word,
   input  logic [citf_pkg::DATA_WIDTH-1:0] req_entry_data,
   input  logic                            req_last_of_table,
   input  citf_pkg::cond_type              dev_cfg,
   input  logic                            res_ready,
   output logic                            res_valid,
   output citf_pkg::write_type             res_item
);
   import citf_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [WORD_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic                  last_ff;
   logic                  matched_ff;
   logic                  matched_in;
   logic                  skipped_ff;
   logic                  skipped_in;
   cond_type              held_ff;
   cond_type              held_in;
   logic                  advance;
   logic                  accept;
   logic                  hit;
   branch_type            branch;

   assign advance   = valid_ff && res_ready;
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign valid_in  = accept || (valid_ff && !advance);
   assign branch    = branch_type'(word_ff[29:28]);

   assign hit = ((held_ff.cut == 4'd0) || (held_ff.cut == dev_cfg.cut)) &&
                ((held_ff.pkg == 4'd0) || (held_ff.pkg == dev_cfg.pkg)) &&
                ((held_ff.intf == 4'd0) || (held_ff.intf == dev_cfg.intf)) &&
                ((held_ff.plat == 4'd0) || (held_ff.plat == dev_cfg.plat)) &&
                ((held_ff.rfe == 8'd0) || (held_ff.rfe == dev_cfg.rfe));

   assign res_valid = valid_ff && !word_ff[BRANCH_BIT] && !word_ff[CHECK_BIT] && matched_ff;
   assign res_item  = '{addr: word_ff[ADDR_WIDTH-1:0], data: data_ff};

   always_comb begin
      matched_in = matched_ff;
      skipped_in = skipped_ff;
      held_in    = held_ff;
      if (advance) begin
         if (word_ff[BRANCH_BIT]) begin
            unique case (branch)
               BR_ENDIF: begin
                  matched_in = 1'b1;
                  skipped_in = 1'b0;
               end
               BR_ELSE: begin
                  matched_in = !skipped_ff;
               end
               BR_IF, BR_ELIF: begin
                  held_in.rfe  = word_ff[7:0];
                  held_in.intf = word_ff[11:8];
                  held_in.pkg  = word_ff[15:12];
                  held_in.plat = word_ff[19:16];
                  held_in.cut  = word_ff[27:24];
               end
               default: held_in = held_ff;
            endcase
         end else if (word_ff[CHECK_BIT]) begin
            if (!skipped_ff) begin
               matched_in = hit;
               skipped_in = hit;
            end else begin
               matched_in = 1'b0;
            end
         end
         if (last_ff) begin
            matched_in = 1'b1;
            skipped_in = 1'b0;
            held_in    = COND_RESET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         matched_ff <= 1'b1;
         skipped_ff <= 1'b0;
         held_ff    <= COND_RESET;
      end else begin
         valid_ff   <= valid_in;
         matched_ff <= matched_in;
         skipped_ff <= skipped_in;
         held_ff    <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_entry_word;
         data_ff <= req_entry_data;
         last_ff <= req_last_of_table;
      end
   end

endmodule

// ===== hdl/citf_rsp.sv =====
// Result register that holds a passed write until the receiver takes it.
module citf_rsp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            res_valid,
   input  citf_pkg::write_type             res_item,
   output logic                            res_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [citf_pkg::ADDR_WIDTH-1:0] rsp_write_addr,
   output logic [citf_pkg::DATA_WIDTH-1:0] rsp_write_data
);
   import citf_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   write_type item_ff;
   logic      load;

   assign res_ready      = !valid_ff || rsp_ready;
   assign load           = res_valid && res_ready;
   assign valid_in       = load || (valid_ff && !rsp_ready);
   assign rsp_valid      = valid_ff;
   assign rsp_write_addr = item_ff.addr;
   assign rsp_write_data = item_ff.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= res_item;
      end
   end

endmodule

// ===== hdl/conditional_init_table_filter_top.sv =====
// Top level of the conditional init table filter.
//
// Table entries arrive on the req_ channel (valid/ready), one request per
// entry: a word, a data value and a last-of-table flag. Branch markers and
// condition checks update the matched and skipped flags or the latched
// conditions and give no result. A plain write that passes the filter leaves
// on the rsp_ channel as an address and a data value; a write that does not
// pass is dropped. One request is taken every cycle while the receiver does
// not stall; the entry is decoded from the input register and a passed write
// is shown from the result register. When the receiver stalls, the result
// register holds the write and one further entry waits in the input register;
// req_ready falls only when both are full. After the last entry of a table
// the flags and latched conditions return to their reset values. Reset
// empties both stages, resets the table state and sets the device registers
// to zero. The user must write the device registers through the csr_ port
// only while the block is idle; the block itself does not enforce this.
module conditional_init_table_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [citf_pkg::WORD_WIDTH-1:0]     req_entry_word,
   input  logic [citf_pkg::DATA_WIDTH-1:0]     req_entry_data,
   input  logic                                req_last_of_table,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [citf_pkg::ADDR_WIDTH-1:0]     rsp_write_addr,
   output logic [citf_pkg::DATA_WIDTH-1:0]     rsp_write_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [citf_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [citf_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [citf_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import citf_pkg::*;

   cond_type  dev_cfg;
   logic      res_valid;
   logic      res_ready;
   write_type res_item;

   citf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dev_cfg     (dev_cfg)
   );

   citf_core u_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_entry_word    (req_entry_word),
      .req_entry_data    (req_entry_data),
      .req_last_of_table (req_last_of_table),
      .dev_cfg           (dev_cfg),
      .res_ready         (res_ready),
      .res_valid         (res_valid),
      .res_item          (res_item)
   );

   citf_rsp u_rsp (
      .clock          (clock),
      .reset          (reset),
      .res_valid      (res_valid),
      .res_item       (res_item),
      .res_ready      (res_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_write_addr (rsp_write_addr),
      .rsp_write_data (rsp_write_data)
   );

`ifndef SYNTHESIS
   a_ready_low_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without a stalled result");

   a_reset_empties_pipe: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("pipeline not empty after reset");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_write_addr) &&
                                     $stable(rsp_write_data)))
      else $error("stalled result changed");
`endif

endmodule
